// File: sv/fdsu_pkg.sv
// Package for the Forth data stack unit: word and depth widths, operation codes,
// stack shift codes and defaults. It depends on nothing and is compiled first.
package fdsu_pkg;

    localparam int unsigned WORD_W          = 32;
    localparam int unsigned DEPTH_W         = 7;
    localparam int unsigned OP_W            = 4;
    localparam int unsigned STACK_DEPTH_DEF = 64;
    localparam int unsigned TOP_N           = 4;

    localparam logic [DEPTH_W-1:0] LIMIT_RESET = DEPTH_W'(64);

    typedef logic signed [WORD_W-1:0] t_word;
    typedef logic [DEPTH_W-1:0]       t_depth;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 4'd0,
        OP_POP   = 4'd1,
        OP_TOP   = 4'd2,
        OP_DUP   = 4'd3,
        OP_SWAP  = 4'd4,
        OP_ADD   = 4'd5,
        OP_DROP  = 4'd6,
        OP_OVER  = 4'd7,
        OP_ROT   = 4'd8,
        OP_2DROP = 4'd9,
        OP_2SWAP = 4'd10,
        OP_2DUP  = 4'd11,
        OP_2OVER = 4'd12
    } t_op;

    typedef enum logic [2:0] {
        SH_DN2  = 3'd0,
        SH_DN1  = 3'd1,
        SH_NONE = 3'd2,
        SH_UP1  = 3'd3,
        SH_UP2  = 3'd4
    } t_shift;

endpackage

// File: sv/fdsu_req_if.sv
// Request channel of the Forth data stack unit: valid, ready and one operation.
// Depends on fdsu_pkg.
interface fdsu_req_if;
    import fdsu_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   req_type;
    t_word             push_word;

    modport source (output valid, req_type, push_word, input ready);
    modport sink   (input valid, req_type, push_word, output ready);
endinterface

// File: sv/fdsu_rsp_if.sv
// Result channel of the Forth data stack unit: valid, ready and one result.
// Depends on fdsu_pkg.
interface fdsu_rsp_if;
    import fdsu_pkg::*;

    logic   valid;
    logic   ready;
    logic   ok;
    t_word  read_word;
    t_depth depth_after;

    modport source (output valid, ok, read_word, depth_after, input ready);
    modport sink   (input valid, ok, read_word, depth_after, output ready);
endinterface

// File: sv/forth_data_stack_unit_top.sv
// Top level of the Forth data stack unit: a bounded stack of 32-bit words.
// Depends on fdsu_pkg, fdsu_req_if and fdsu_rsp_if.
//
// Usage:
// Each transfer on i_req carries one stack operation; each operation gives
// exactly one transfer on o_rsp with the success flag, the popped or peeked
// word and the depth after the operation.
// An accepted operation waits in the input register and is done from there once
// the result register is free; it loads the result register, which drives
// o_rsp.valid and holds the result until the transfer on o_rsp.
// One operation is taken every cycle while o_rsp moves: the top four entries sit
// in registers, the next two wait in a fill buffer, and the rest live in two
// memory banks that each see at most one write and one registered read per cycle.
// When the receiver stalls, the result register holds and the input register
// fills; i_req.ready then drops until o_rsp moves again.
// The limit register is to be written through i_cfg_we and i_cfg_data only while
// the unit is idle; the block does not enforce it. Reset empties the stack, sets
// the limit to 64, clears both channel stages; stale words stay above the depth.
module forth_data_stack_unit_top #(
    parameter int unsigned STACK_DEPTH = fdsu_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fdsu_pkg::DEPTH_W-1:0]  i_cfg_data,
    fdsu_req_if.sink                      i_req,
    fdsu_rsp_if.source                    o_rsp
);
    import fdsu_pkg::*;

    localparam int unsigned SD_W   = $clog2(STACK_DEPTH + 1);
    localparam int unsigned CAP_W  = ((SD_W > DEPTH_W) ? SD_W : DEPTH_W) + 1;
    localparam int unsigned WIN_N  = TOP_N + 2;
    localparam int unsigned BANK_N = (STACK_DEPTH + 1) / 2;
    localparam int unsigned BANK_W = $clog2(STACK_DEPTH) - 1;

    logic            r_in_valid;
    logic [OP_W-1:0] r_in_op;
    t_word           r_in_word;

    logic            r_out_valid;
    logic            r_out_ok;
    t_word           r_out_word;
    t_depth          r_out_depth;

    t_depth          r_depth;
    t_depth          r_limit;
    t_word           r_top [TOP_N];
    t_word           r_fill [2];
    logic [1:0]      r_fill_mem;
    logic            r_fill_par;
    t_word           r_rd_even;
    t_word           r_rd_odd;
    t_word           r_mem_even [BANK_N];
    t_word           r_mem_odd [BANK_N];

    t_word           n_top [TOP_N];
    t_word           n_fill [2];
    logic [1:0]      n_fill_mem;
    t_depth          n_depth;

    t_word           win [WIN_N];
    logic            fire;
    logic            op_known;
    logic [2:0]      need;
    logic [1:0]      grow;
    logic [1:0]      shrink;
    t_shift          shift;
    logic            rd_en;
    logic [TOP_N-1:0] ov_en;
    t_word           ov_val [TOP_N];
    logic [CAP_W-1:0] cap;
    logic [CAP_W-1:0] depth_ext;
    logic [CAP_W-1:0] depth_sum;
    logic [CAP_W-1:0] depth_nx;
    logic [CAP_W-1:0] rd_addr0;
    logic [CAP_W-1:0] rd_addr1;
    logic [CAP_W-1:0] wr_addr3;
    logic [CAP_W-1:0] wr_addr2;
    logic            wr_en3;
    logic            wr_en2;
    logic            we_even;
    logic            we_odd;
    logic [BANK_W-1:0] wa_even;
    logic [BANK_W-1:0] wa_odd;
    logic [BANK_W-1:0] ra_even;
    logic [BANK_W-1:0] ra_odd;
    t_word           wd_even;
    t_word           wd_odd;
    logic            ok;

    assign fire        = r_in_valid && (!r_out_valid || o_rsp.ready);
    assign i_req.ready = !r_in_valid || fire;

    always_comb begin
        for (int k = 0; k < TOP_N; k++) begin
            win[k] = r_top[k];
        end
        win[TOP_N]   = r_fill_mem[0] ? (r_fill_par ? r_rd_odd : r_rd_even) : r_fill[0];
        win[TOP_N+1] = r_fill_mem[1] ? (r_fill_par ? r_rd_even : r_rd_odd) : r_fill[1];
    end

    always_comb begin
        op_known = 1'b1;
        need     = 3'd0;
        grow     = 2'd0;
        shrink   = 2'd0;
        shift    = SH_NONE;
        rd_en    = 1'b0;
        ov_en    = '0;
        for (int k = 0; k < TOP_N; k++) begin
            ov_val[k] = win[k];
        end
        case (r_in_op)
            OP_PUSH: begin
                grow = 2'd1; shift = SH_UP1;
                ov_en[0] = 1'b1; ov_val[0] = r_in_word;
            end
            OP_POP: begin
                need = 3'd1; shrink = 2'd1; shift = SH_DN1; rd_en = 1'b1;
            end
            OP_TOP: begin
                need = 3'd1; rd_en = 1'b1;
            end
            OP_DUP: begin
                need = 3'd1; grow = 2'd1; shift = SH_UP1;
                ov_en[0] = 1'b1; ov_val[0] = win[0];
            end
            OP_SWAP: begin
                need = 3'd2;
                ov_en[1:0] = 2'b11; ov_val[0] = win[1]; ov_val[1] = win[0];
            end
            OP_ADD: begin
                need = 3'd2; shrink = 2'd1; shift = SH_DN1;
                ov_en[0] = 1'b1; ov_val[0] = win[0] + win[1];
            end
            OP_DROP: begin
                need = 3'd1; shrink = 2'd1; shift = SH_DN1;
            end
            OP_OVER: begin
                need = 3'd2; grow = 2'd1; shift = SH_UP1;
                ov_en[0] = 1'b1; ov_val[0] = win[1];
            end
            OP_ROT: begin
                need = 3'd3;
                ov_en[2:0] = 3'b111;
                ov_val[0] = win[2]; ov_val[1] = win[0]; ov_val[2] = win[1];
            end
            OP_2DROP: begin
                need = 3'd2; shrink = 2'd2; shift = SH_DN2;
            end
            OP_2SWAP: begin
                need = 3'd4;
                ov_en = 4'b1111;
                ov_val[0] = win[2]; ov_val[1] = win[3];
                ov_val[2] = win[0]; ov_val[3] = win[1];
            end
            OP_2DUP: begin
                need = 3'd2; grow = 2'd2; shift = SH_UP2;
                ov_en[1:0] = 2'b11; ov_val[0] = win[0]; ov_val[1] = win[1];
            end
            OP_2OVER: begin
                need = 3'd4; grow = 2'd2; shift = SH_UP2;
                ov_en[1:0] = 2'b11; ov_val[0] = win[2]; ov_val[1] = win[3];
            end
            default: begin
                op_known = 1'b0;
            end
        endcase
    end

    assign depth_ext = CAP_W'(r_depth);
    assign cap = (CAP_W'(r_limit) < CAP_W'(STACK_DEPTH)) ? CAP_W'(r_limit)
                                                         : CAP_W'(STACK_DEPTH);
    assign ok = op_known && (depth_ext >= CAP_W'(need))
                && ((depth_ext + CAP_W'(grow)) <= cap);
    assign depth_sum = depth_ext + CAP_W'(grow) - CAP_W'(shrink);
    assign n_depth   = DEPTH_W'(depth_sum);
    assign depth_nx  = (fire && ok) ? depth_sum : depth_ext;

    // Entries below the fill buffer are kept in memory at their distance from
    // the bottom of the stack; two neighbors always fall in different banks.
    assign rd_addr0 = depth_nx - CAP_W'(TOP_N + 1);
    assign rd_addr1 = depth_nx - CAP_W'(TOP_N + 2);
    assign ra_even  = rd_addr0[0] ? rd_addr1[BANK_W:1] : rd_addr0[BANK_W:1];
    assign ra_odd   = rd_addr0[0] ? rd_addr0[BANK_W:1] : rd_addr1[BANK_W:1];
    assign wr_addr3 = depth_ext - CAP_W'(TOP_N);
    assign wr_addr2 = depth_ext - CAP_W'(TOP_N - 1);
    assign wr_en3   = fire && ok && (grow != 2'd0) && (depth_ext >= CAP_W'(TOP_N));
    assign wr_en2   = fire && ok && (grow == 2'd2) && (depth_ext >= CAP_W'(TOP_N - 1));

    always_comb begin
        we_even = 1'b0;
        we_odd  = 1'b0;
        wa_even = wr_addr3[BANK_W:1];
        wa_odd  = wr_addr3[BANK_W:1];
        wd_even = r_top[TOP_N-1];
        wd_odd  = r_top[TOP_N-1];
        if (wr_en3) begin
            if (wr_addr3[0]) begin
                we_odd  = 1'b1;
                wa_odd  = wr_addr3[BANK_W:1];
                wd_odd  = r_top[TOP_N-1];
            end else begin
                we_even = 1'b1;
                wa_even = wr_addr3[BANK_W:1];
                wd_even = r_top[TOP_N-1];
            end
        end
        if (wr_en2) begin
            if (wr_addr2[0]) begin
                we_odd  = 1'b1;
                wa_odd  = wr_addr2[BANK_W:1];
                wd_odd  = r_top[TOP_N-2];
            end else begin
                we_even = 1'b1;
                wa_even = wr_addr2[BANK_W:1];
                wd_even = r_top[TOP_N-2];
            end
        end
    end

    always_comb begin
        for (int k = 0; k < TOP_N; k++) begin
            case (shift)
                SH_UP1:  n_top[k] = win[(k >= 1) ? k - 1 : 0];
                SH_UP2:  n_top[k] = win[(k >= 2) ? k - 2 : 0];
                SH_DN1:  n_top[k] = win[k + 1];
                SH_DN2:  n_top[k] = win[k + 2];
                default: n_top[k] = win[k];
            endcase
            if (ov_en[k]) begin
                n_top[k] = ov_val[k];
            end
        end
    end

    always_comb begin
        n_fill[0]  = win[TOP_N];
        n_fill[1]  = win[TOP_N+1];
        n_fill_mem = 2'b00;
        if (fire && ok) begin
            case (shift)
                SH_UP1: begin
                    n_fill[0] = win[TOP_N-1];
                    n_fill[1] = win[TOP_N];
                end
                SH_UP2: begin
                    n_fill[0] = win[TOP_N-2];
                    n_fill[1] = win[TOP_N-1];
                end
                SH_DN1: begin
                    n_fill[0]  = win[TOP_N+1];
                    n_fill_mem = 2'b10;
                end
                SH_DN2: begin
                    n_fill_mem = 2'b11;
                end
                default: begin
                    n_fill_mem = 2'b00;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_depth     <= '0;
            r_limit     <= LIMIT_RESET;
        end else begin
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (fire && ok) begin
                r_depth <= n_depth;
            end
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op   <= i_req.req_type;
            r_in_word <= i_req.push_word;
        end
        if (fire) begin
            r_out_ok    <= ok;
            r_out_word  <= (ok && rd_en) ? r_top[0] : '0;
            r_out_depth <= ok ? n_depth : r_depth;
        end
        if (fire && ok) begin
            r_top <= n_top;
        end
        r_fill     <= n_fill;
        r_fill_mem <= n_fill_mem;
        r_fill_par <= rd_addr0[0];
    end

    always_ff @(posedge i_clk) begin
        if (we_even) begin
            r_mem_even[wa_even] <= wd_even;
        end
        if (we_odd) begin
            r_mem_odd[wa_odd] <= wd_odd;
        end
        r_rd_even <= r_mem_even[ra_even];
        r_rd_odd  <= r_mem_odd[ra_odd];
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.ok          = r_out_ok;
    assign o_rsp.read_word   = r_out_word;
    assign o_rsp.depth_after = r_out_depth;

endmodule
